// ----- design/bracket_comment_balance_checker_defines.svh -----
// assertion macros for the bracket and comment balance checker
// no dependencies; taken in by every rtl file that carries assertions
`ifndef BRACKET_COMMENT_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_COMMENT_BALANCE_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define BCBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequence checked in the cycle after the trigger
`define BCBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BCBC_ASSERT(lbl, clk, rstn, prop, msg)
`define BCBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/bcbc_pkg.sv -----
// shared types and constants for the bracket and comment balance checker
// no dependencies; used by every module of the block
package bcbc_pkg;

    // default number of open symbols the stack can hold
    localparam int unsigned STACK_DEPTH_DEFAULT = 128;

    // queue between front and back, power of two
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes of interest
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACK = 8'h5b;
    localparam logic [7:0] CHAR_RBRACK = 8'h5d;
    localparam logic [7:0] CHAR_LBRACE = 8'h7b;
    localparam logic [7:0] CHAR_RBRACE = 8'h7d;
    localparam logic [7:0] CHAR_SLASH  = 8'h2f;
    localparam logic [7:0] CHAR_STAR   = 8'h2a;

    typedef enum logic [1:0] {
        KIND_PAREN   = 2'd0,
        KIND_BRACKET = 2'd1,
        KIND_BRACE   = 2'd2,
        KIND_COMMENT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OUT_PAIRED     = 2'd0,
        OUT_LEFT_OPEN  = 2'd1,
        OUT_RIGHT_OPEN = 2'd2,
        OUT_OVERFLOW   = 2'd3
    } outcome_t;

    // stack operation decoded by the front
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // pending half of a comment delimiter
    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_SLASH = 3'b010,
        PEND_STAR  = 3'b100
    } pend_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [1:0] symbol_kind;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t   op;
        kind_t kind;
        logic  last;
    } op_item_t;

endpackage

// ----- design/bcbc_front.sv -----
// front end: takes text bytes and decodes them into stack operations
// depends on bcbc_pkg and the assertion macro header
`include "bracket_comment_balance_checker_defines.svh"

module bcbc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  bcbc_pkg::in_item_t s_data,
    input  logic               s_valid,
    output logic               s_ready,
    output bcbc_pkg::op_item_t op_item,
    output logic               op_valid,
    input  logic               op_ready
);
    import bcbc_pkg::*;

    pend_t pend_reg;
    pend_t pend_next;
    pend_t pend_dec;
    logic  take;

    // handshake passes straight on to the queue
    assign s_ready  = op_ready;
    assign op_valid = s_valid;
    assign take     = s_valid && op_ready;

    // decode one byte against the pending delimiter half
    always_comb begin
        op_item.op   = OP_NONE;
        op_item.kind = KIND_PAREN;
        op_item.last = s_data.last_byte;
        pend_dec     = PEND_NONE;
        if (pend_reg == PEND_SLASH && s_data.text_byte == CHAR_STAR) begin
            op_item.op   = OP_PUSH;
            op_item.kind = KIND_COMMENT;
        end else if (pend_reg == PEND_STAR && s_data.text_byte == CHAR_SLASH) begin
            op_item.op   = OP_POP;
            op_item.kind = KIND_COMMENT;
        end else begin
            unique case (s_data.text_byte)
                CHAR_LPAREN: begin
                    op_item.op   = OP_PUSH;
                    op_item.kind = KIND_PAREN;
                end
                CHAR_RPAREN: begin
                    op_item.op   = OP_POP;
                    op_item.kind = KIND_PAREN;
                end
                CHAR_LBRACK: begin
                    op_item.op   = OP_PUSH;
                    op_item.kind = KIND_BRACKET;
                end
                CHAR_RBRACK: begin
                    op_item.op   = OP_POP;
                    op_item.kind = KIND_BRACKET;
                end
                CHAR_LBRACE: begin
                    op_item.op   = OP_PUSH;
                    op_item.kind = KIND_BRACE;
                end
                CHAR_RBRACE: begin
                    op_item.op   = OP_POP;
                    op_item.kind = KIND_BRACE;
                end
                CHAR_SLASH: pend_dec = PEND_SLASH;
                CHAR_STAR:  pend_dec = PEND_STAR;
                default:    pend_dec = PEND_NONE;
            endcase
        end
    end

    // pending flag follows each item, cleared at the end of a text
    always_comb begin
        pend_next = pend_reg;
        if (take) begin
            pend_next = s_data.last_byte ? PEND_NONE : pend_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `BCBC_ASSERT_NEXT(a_pend_clear_on_last, aclk, aresetn, take && s_data.last_byte, pend_reg == PEND_NONE, "pending delimiter survived the end of a text")

endmodule

// ----- design/bcbc_queue.sv -----
// short queue of decoded items between front and back
// depends on bcbc_pkg and the assertion macro header
`include "bracket_comment_balance_checker_defines.svh"

module bcbc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  bcbc_pkg::op_item_t wr_item,
    input  logic               wr_valid,
    output logic               wr_ready,
    output bcbc_pkg::op_item_t rd_item,
    output logic               rd_valid,
    input  logic               rd_ready
);
    import bcbc_pkg::*;

    op_item_t            q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   fill_next;
    logic                wr_take;
    logic                rd_take;

    assign wr_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_item  = q_mem[rd_ptr_reg];
    assign wr_take  = wr_valid && wr_ready;
    assign rd_take  = rd_valid && rd_ready;

    // pointers wrap on the power-of-two depth
    always_comb begin
        wr_ptr_next = wr_take ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_take ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_take && !rd_take) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (rd_take && !wr_take) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_take) begin
            q_mem[wr_ptr_reg] <= wr_item;
        end
    end

    `BCBC_ASSERT_NEXT(a_queue_fill_up, aclk, aresetn, wr_take && !rd_take, fill_reg == $past(fill_reg) + QCNT_W'(1), "queue fill did not follow a lone write")

endmodule

// ----- design/bcbc_back.sv -----
// back end: open-symbol stack, first-error latch and result register
// depends on bcbc_pkg and the assertion macro header
`include "bracket_comment_balance_checker_defines.svh"

module bcbc_back #(
    parameter int unsigned STACK_DEPTH = bcbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bcbc_pkg::op_item_t  op_item,
    input  logic                op_valid,
    output logic                op_ready,
    output bcbc_pkg::out_item_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);
    import bcbc_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // entries below the top; the top itself lives in top_reg
    kind_t           stack_mem [STACK_DEPTH];

    logic [CW-1:0]   count_reg,  count_next;
    kind_t           top_reg,    top_next;
    kind_t           bottom_reg, bottom_next;
    kind_t           below_rd_reg;
    kind_t           byp_val_reg;
    logic            byp_sel_reg, byp_sel_next;
    logic            err_reg,    err_next;
    outcome_t        err_out_reg, err_out_next;
    kind_t           err_kind_reg, err_kind_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    kind_t           below;
    logic            out_free;
    logic            take;
    logic            push_wr;
    logic [CW-1:0]   count_dec;
    logic [CW-1:0]   count_sub2;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;

    // second entry from the top, with forwarding of a same-cycle write
    assign below    = byp_sel_reg ? byp_val_reg : below_rd_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign op_ready = !op_item.last || out_free;
    assign take     = op_valid && op_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign count_dec = count_reg - CW'(1);
    assign wr_addr   = count_dec[AW-1:0];

    // stack operation, error latch and verdict
    always_comb begin
        count_next    = count_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        err_next      = err_reg;
        err_out_next  = err_out_reg;
        err_kind_next = err_kind_reg;
        push_wr       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (take && !err_reg) begin
            unique case (op_item.op)
                OP_PUSH: begin
                    if (count_reg == FULL_COUNT) begin
                        err_next      = 1'b1;
                        err_out_next  = OUT_OVERFLOW;
                        err_kind_next = op_item.kind;
                    end else begin
                        push_wr    = (count_reg != '0);
                        top_next   = op_item.kind;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0) begin
                            bottom_next = op_item.kind;
                        end
                    end
                end
                OP_POP: begin
                    if (count_reg == '0) begin
                        err_next      = 1'b1;
                        err_out_next  = OUT_RIGHT_OPEN;
                        err_kind_next = op_item.kind;
                    end else if (top_reg == op_item.kind) begin
                        count_next = count_dec;
                        top_next   = below;
                    end else begin
                        err_next      = 1'b1;
                        err_out_next  = OUT_LEFT_OPEN;
                        err_kind_next = top_reg;
                    end
                end
                default: ;
            endcase
        end

        // end of text: give the verdict and start afresh
        if (take && op_item.last) begin
            m_valid_next = 1'b1;
            if (err_next) begin
                m_data_next.outcome     = err_out_next;
                m_data_next.symbol_kind = err_kind_next;
            end else if (count_next == '0) begin
                m_data_next.outcome     = OUT_PAIRED;
                m_data_next.symbol_kind = KIND_PAREN;
            end else begin
                m_data_next.outcome     = OUT_LEFT_OPEN;
                m_data_next.symbol_kind = bottom_next;
            end
            count_next    = '0;
            err_next      = 1'b0;
            err_out_next  = OUT_PAIRED;
            err_kind_next = KIND_PAREN;
        end
    end

    // read address tracks the entry under the next top
    assign count_sub2   = count_next - CW'(2);
    assign rd_addr      = count_sub2[AW-1:0];
    assign byp_sel_next = push_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            err_reg      <= 1'b0;
            err_out_reg  <= OUT_PAIRED;
            err_kind_reg <= KIND_PAREN;
            m_valid_reg  <= 1'b0;
            byp_sel_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            err_reg      <= err_next;
            err_out_reg  <= err_out_next;
            err_kind_reg <= err_kind_next;
            m_valid_reg  <= m_valid_next;
            byp_sel_reg  <= byp_sel_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        bottom_reg  <= bottom_next;
        byp_val_reg <= top_reg;
        m_data_reg  <= m_data_next;
    end

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (push_wr) begin
            stack_mem[wr_addr] <= top_reg;
        end
        below_rd_reg <= stack_mem[rd_addr];
    end

    `BCBC_ASSERT_NEXT(a_last_restarts, aclk, aresetn, take && op_item.last, count_reg == '0 && !err_reg && m_valid_reg, "state not cleared after the end of a text")
    `BCBC_ASSERT_NEXT(a_first_error_kept, aclk, aresetn, err_reg && !(take && op_item.last), err_reg && $stable(err_out_reg) && $stable(err_kind_reg), "latched error changed before the end of a text")
    `BCBC_ASSERT_NEXT(a_overflow_flagged, aclk, aresetn, take && !err_reg && !op_item.last && op_item.op == OP_PUSH && count_reg == FULL_COUNT, err_reg && err_out_reg == OUT_OVERFLOW && count_reg == FULL_COUNT, "push on a full stack not flagged")

endmodule

// ----- design/bracket_comment_balance_checker.sv -----
// top level of the bracket and comment balance checker
// depends on bcbc_pkg, bcbc_front, bcbc_queue and bcbc_back
//
//  port group   direction  carries
//  s_*          in         one text byte and its end-of-text mark per item
//  m_*          out        verdict and unpaired symbol kind, one per text
//
// one text byte is taken every cycle while s_ready is high; the stack does one push or pop per cycle
// at the earliest m_valid rises once the last byte has passed the queue and the result register
// aresetn (synchronous, active low) clears the stack count, error latch and queue
// the stack memory needs no clearing pass: entries are only used once pushed
// a stalled m_ready halts the back at an end-of-text item; the queue takes one more, then s_ready falls

module bracket_comment_balance_checker #(
    parameter int unsigned STACK_DEPTH = bcbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bcbc_pkg::in_item_t  s_data,
    input  logic                s_valid,
    output logic                s_ready,
    output bcbc_pkg::out_item_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);
    import bcbc_pkg::*;

    op_item_t front_item;
    logic     front_valid;
    logic     front_ready;
    op_item_t back_item;
    logic     back_valid;
    logic     back_ready;

    // byte decoding and delimiter pairing
    bcbc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .op_item  (front_item),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    // decoupling queue
    bcbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    // stack and verdict
    bcbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_item  (back_item),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .m_data   (m_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

endmodule
